### src/bced_pkg.sv
// ----------------------------------------------------------------------------
// bced_pkg
// Types and constants shared by the button click event detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bced_pkg;

  localparam int unsigned NOW_WIDTH    = 32;
  localparam int unsigned PERIOD_WIDTH = 16;
  localparam int unsigned EV_WIDTH     = 5;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam int unsigned EV_DOWN   = 0;
  localparam int unsigned EV_UP     = 1;
  localparam int unsigned EV_LONG   = 2;
  localparam int unsigned EV_CLICK  = 3;
  localparam int unsigned EV_DOUBLE = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_GAP_TIME  = 2'd3;

  localparam logic [PERIOD_WIDTH-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [PERIOD_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [PERIOD_WIDTH-1:0] CLICK_GAP_RESET  = 16'd300;

  typedef enum logic [2:0] {
    ST_RELEASED    = 3'd0,
    ST_DEB_PRESS   = 3'd1,
    ST_PRESSED     = 3'd2,
    ST_DEB_RELEASE = 3'd3,
    ST_WAIT_SECOND = 3'd4,
    ST_DEB_SECOND  = 3'd5
  } state_t;

  typedef struct packed {
    logic                    press_level;
    logic [PERIOD_WIDTH-1:0] debounce_time;
    logic [PERIOD_WIDTH-1:0] long_press_time;
    logic [PERIOD_WIDTH-1:0] click_gap_time;
  } cfg_t;

endpackage

`default_nettype wire

### src/bced_if.sv
// ----------------------------------------------------------------------------
// bced_if
// Valid/ready channels for pin samples and event reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface bced_in_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_time;
  logic        collect;

  modport source (output valid, output pin_level, output now_time, output collect,
                  input ready);
  modport sink (input valid, input pin_level, input now_time, input collect,
                output ready);
endinterface

interface bced_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] pending_mask;
  logic       is_pressed;

  modport source (output valid, output pending_mask, output is_pressed, input ready);
  modport sink (input valid, input pending_mask, input is_pressed, output ready);
endinterface

`default_nettype wire

### src/bced_cfg_regs.sv
// ----------------------------------------------------------------------------
// bced_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bced_cfg_regs
  import bced_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire logic [CFG_IDX_W-1:0]    wr_index,
  input  wire logic [PERIOD_WIDTH-1:0] wr_data,
  output cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_level     <= 1'b0;
      cfg.debounce_time   <= DEBOUNCE_RESET;
      cfg.long_press_time <= LONG_PRESS_RESET;
      cfg.click_gap_time  <= CLICK_GAP_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_ACTIVE_LEVEL:    cfg.press_level     <= wr_data[0];
        CFG_DEBOUNCE_TIME:   cfg.debounce_time   <= wr_data;
        CFG_LONG_PRESS_TIME: cfg.long_press_time <= wr_data;
        CFG_CLICK_GAP_TIME:  cfg.click_gap_time  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/bced_fsm.sv
// ----------------------------------------------------------------------------
// bced_fsm
// Debounce, long-press and click/double-click state machine with the
// pending event mask. Updates once per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bced_fsm
  import bced_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic                  pin_level,
  input  wire logic [NOW_WIDTH-1:0]  now_time,
  input  wire logic                  collect,
  input  cfg_t                       cfg,
  output logic [EV_WIDTH-1:0]        pending_mask,
  output logic                       is_pressed
);

  state_t                 state, state_next;
  logic                   btn_down, btn_down_next;
  logic                   long_done, long_done_next;
  logic                   first_click, first_click_next;
  logic [TIME_WIDTH-1:0]  change_stamp, change_stamp_next;
  logic [TIME_WIDTH-1:0]  press_stamp, press_stamp_next;
  logic [TIME_WIDTH-1:0]  release_stamp, release_stamp_next;
  logic [EV_WIDTH-1:0]    event_bits;
  logic [EV_WIDTH-1:0]    new_events;

  logic                   pressed;
  logic [TIME_WIDTH-1:0]  now_t;
  logic                   deb_over;
  logic                   long_over;
  logic                   gap_over;

  assign pressed   = (pin_level == cfg.press_level);
  assign now_t     = TIME_WIDTH'(now_time);
  assign deb_over  = TIME_WIDTH'(now_t - change_stamp) >= TIME_WIDTH'(cfg.debounce_time);
  assign long_over = TIME_WIDTH'(now_t - press_stamp) >= TIME_WIDTH'(cfg.long_press_time);
  assign gap_over  = TIME_WIDTH'(now_t - release_stamp) >= TIME_WIDTH'(cfg.click_gap_time);

  always_comb begin
    state_next = state;
    case (state)
      ST_RELEASED: begin
        if (pressed) state_next = ST_DEB_PRESS;
      end
      ST_DEB_PRESS, ST_DEB_SECOND: begin
        if (!pressed) begin
          state_next = (state == ST_DEB_PRESS) ? ST_RELEASED : ST_WAIT_SECOND;
        end else if (deb_over) begin
          state_next = ST_PRESSED;
        end
      end
      ST_PRESSED: begin
        if (!pressed) state_next = ST_DEB_RELEASE;
      end
      ST_DEB_RELEASE: begin
        if (pressed) begin
          state_next = ST_PRESSED;
        end else if (deb_over) begin
          state_next = (long_done || first_click) ? ST_RELEASED : ST_WAIT_SECOND;
        end
      end
      ST_WAIT_SECOND: begin
        if (pressed) begin
          state_next = ST_DEB_SECOND;
        end else if (gap_over) begin
          state_next = ST_RELEASED;
        end
      end
      default: state_next = ST_RELEASED;
    endcase
  end

  always_comb begin
    btn_down_next       = btn_down;
    long_done_next      = long_done;
    first_click_next    = first_click;
    change_stamp_next   = change_stamp;
    press_stamp_next    = press_stamp;
    release_stamp_next  = release_stamp;
    new_events          = '0;
    case (state)
      ST_RELEASED: begin
        if (pressed) change_stamp_next = now_t;
      end
      ST_DEB_PRESS, ST_DEB_SECOND: begin
        if (pressed && deb_over) begin
          btn_down_next        = 1'b1;
          press_stamp_next     = now_t;
          long_done_next       = 1'b0;
          new_events[EV_DOWN]  = 1'b1;
        end
      end
      ST_PRESSED: begin
        if (!pressed) begin
          change_stamp_next = now_t;
        end else if (!long_done && long_over) begin
          long_done_next      = 1'b1;
          new_events[EV_LONG] = 1'b1;
        end
      end
      ST_DEB_RELEASE: begin
        if (!pressed && deb_over) begin
          btn_down_next       = 1'b0;
          new_events[EV_UP]   = 1'b1;
          if (long_done) begin
            first_click_next = 1'b0;
          end else if (!first_click) begin
            first_click_next   = 1'b1;
            release_stamp_next = now_t;
          end else begin
            new_events[EV_DOUBLE] = 1'b1;
            first_click_next      = 1'b0;
          end
        end
      end
      ST_WAIT_SECOND: begin
        if (pressed) begin
          change_stamp_next = now_t;
        end else if (gap_over) begin
          new_events[EV_CLICK] = 1'b1;
          first_click_next     = 1'b0;
        end
      end
      default: first_click_next = 1'b0;
    endcase
  end

  assign pending_mask = event_bits | new_events;
  assign is_pressed   = btn_down_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RELEASED;
      btn_down       <= 1'b0;
      long_done      <= 1'b0;
      first_click    <= 1'b0;
      change_stamp   <= '0;
      press_stamp    <= '0;
      release_stamp  <= '0;
      event_bits     <= '0;
    end else if (step) begin
      state          <= state_next;
      btn_down       <= btn_down_next;
      long_done      <= long_done_next;
      first_click    <= first_click_next;
      change_stamp   <= change_stamp_next;
      press_stamp    <= press_stamp_next;
      release_stamp  <= release_stamp_next;
      event_bits     <= collect ? '0 : pending_mask;
    end
  end

endmodule

`default_nettype wire

### src/button_click_event_detector_core.sv
// An accepted sample goes to the sample register, its result to the result register.
// Throughput: one sample per cycle unless result back-pressure stalls; the state update
// is a single pass of compare-and-transition logic between sample and result registers.
// Reset: synchronous, active high; clears the state machine, the pending
// event mask and both pipeline stages, and loads the register defaults.
// ----------------------------------------------------------------------------
// button_click_event_detector_core
// Button pin sampler with debounce, long press and click/double-click events.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_event_detector_core
  import bced_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  bced_in_if.sink                      sample,
  bced_out_if.source                   result,
  input  wire logic                    wr_en,
  input  wire logic [CFG_IDX_W-1:0]    wr_index,
  input  wire logic [PERIOD_WIDTH-1:0] wr_data
);

  cfg_t                  cfg;
  logic                  s1_valid;
  logic                  s1_pin;
  logic [NOW_WIDTH-1:0]  s1_now;
  logic                  s1_collect;
  logic                  res_valid;
  logic [EV_WIDTH-1:0]   res_mask;
  logic                  res_pressed;
  logic                  advance;
  logic                  step;
  logic [EV_WIDTH-1:0]   mask_next;
  logic                  pressed_next;

  assign advance      = !res_valid || result.ready;
  assign sample.ready = !s1_valid || advance;
  assign step         = s1_valid && advance;

  bced_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  bced_fsm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .pin_level    (s1_pin),
    .now_time     (s1_now),
    .collect      (s1_collect),
    .cfg          (cfg),
    .pending_mask (mask_next),
    .is_pressed   (pressed_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_pin     <= sample.pin_level;
      s1_now     <= sample.now_time;
      s1_collect <= sample.collect;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_mask    <= mask_next;
      res_pressed <= pressed_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.pending_mask = res_mask;
  assign result.is_pressed   = res_pressed;

endmodule

`default_nettype wire

### src/bced_checker.sv
// ----------------------------------------------------------------------------
// bced_checker
// Port-level checks for the button click event detector.
// ----------------------------------------------------------------------------
`default_nettype none

module bced_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] out_mask,
  input wire logic       out_pressed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_mask) && $stable(out_pressed))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_result_has_sample: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted sample");

  a_double_with_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_mask[4] |-> out_mask[1])
    else $error("double click reported without release");

endmodule

bind button_click_event_detector_core bced_checker u_bced_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_mask    (result.pending_mask),
  .out_pressed (result.is_pressed)
);

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button click event detector core. Pin-sample
// transactions come from a queue through a clocked driver. A clocked monitor
// compares each report transaction with the event mask and pressed state that
// a behavioral copy of the detector predicts. Both channels idle at random.
// The register settings change between phases, and the extremes are among
// them.
// ----------------------------------------------------------------------------

module tb
  import bced_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASE_ITEMS = 240;

  typedef struct packed {
    logic                 pin;
    logic [NOW_WIDTH-1:0] stamp;
    logic                 collect;
  } pin_sample_t;

  typedef struct packed {
    logic [EV_WIDTH-1:0] mask;
    logic                pressed;
  } event_report_t;

  logic clk;
  logic rst;
  logic                    wr_en;
  logic [CFG_IDX_W-1:0]    wr_index;
  logic [PERIOD_WIDTH-1:0] wr_data;

  bced_in_if  sample_ch ();
  bced_out_if result_ch ();

  button_click_event_detector_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  pin_sample_t   samples_todo[$];
  event_report_t reports_due[$];
  pin_sample_t   in_flight;
  event_report_t want;

  cfg_t                 det_cfg;
  state_t               det_state;
  logic                 held;
  logic                 long_fired;
  logic                 click_armed;
  logic [NOW_WIDTH-1:0] chg_stamp;
  logic [NOW_WIDTH-1:0] press_stamp;
  logic [NOW_WIDTH-1:0] rel_stamp;
  logic [EV_WIDTH-1:0]  ev_pending;

  logic [NOW_WIDTH-1:0] sim_ms;
  int unsigned queued;
  int unsigned err_count;
  int unsigned report_idx;
  int unsigned cycles;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned idle_pct;
  int unsigned holds_asked;
  int unsigned holds_served;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic flag_mismatch(input string msg);
    if (err_count < 30) begin
      $display("mismatch: %s", msg);
    end
    err_count++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 93) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic bit period_met(input logic [NOW_WIDTH-1:0] now,
                                    input logic [NOW_WIDTH-1:0] since,
                                    input logic [PERIOD_WIDTH-1:0] span);
    logic [NOW_WIDTH-1:0] diff;
    diff = now - since;
    return diff >= NOW_WIDTH'(span);
  endfunction

  function automatic event_report_t advance_detector(input pin_sample_t s);
    logic          hit;
    event_report_t r;
    hit = (s.pin == det_cfg.press_level);
    case (det_state)
      ST_RELEASED: begin
        if (hit) begin
          chg_stamp = s.stamp;
          det_state = ST_DEB_PRESS;
        end
      end
      ST_DEB_PRESS, ST_DEB_SECOND: begin
        if (!hit) begin
          if (det_state == ST_DEB_PRESS) begin
            det_state = ST_RELEASED;
          end else begin
            det_state = ST_WAIT_SECOND;
          end
        end else if (period_met(s.stamp, chg_stamp, det_cfg.debounce_time)) begin
          held = 1'b1;
          press_stamp = s.stamp;
          long_fired = 1'b0;
          ev_pending[EV_DOWN] = 1'b1;
          det_state = ST_PRESSED;
        end
      end
      ST_PRESSED: begin
        if (!hit) begin
          chg_stamp = s.stamp;
          det_state = ST_DEB_RELEASE;
        end else if (!long_fired &&
                     period_met(s.stamp, press_stamp, det_cfg.long_press_time)) begin
          long_fired = 1'b1;
          ev_pending[EV_LONG] = 1'b1;
        end
      end
      ST_DEB_RELEASE: begin
        if (hit) begin
          det_state = ST_PRESSED;
        end else if (period_met(s.stamp, chg_stamp, det_cfg.debounce_time)) begin
          held = 1'b0;
          ev_pending[EV_UP] = 1'b1;
          if (long_fired) begin
            click_armed = 1'b0;
            det_state = ST_RELEASED;
          end else if (!click_armed) begin
            click_armed = 1'b1;
            rel_stamp = s.stamp;
            det_state = ST_WAIT_SECOND;
          end else begin
            ev_pending[EV_DOUBLE] = 1'b1;
            click_armed = 1'b0;
            det_state = ST_RELEASED;
          end
        end
      end
      ST_WAIT_SECOND: begin
        if (hit) begin
          chg_stamp = s.stamp;
          det_state = ST_DEB_SECOND;
        end else if (period_met(s.stamp, rel_stamp, det_cfg.click_gap_time)) begin
          ev_pending[EV_CLICK] = 1'b1;
          click_armed = 1'b0;
          det_state = ST_RELEASED;
        end
      end
      default: begin
        det_state = ST_RELEASED;
        click_armed = 1'b0;
      end
    endcase
    r.mask = ev_pending;
    r.pressed = held;
    if (s.collect) begin
      ev_pending = '0;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        reports_due.push_back(advance_detector(in_flight));
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          sample_ch.valid <= 1'b0;
        end else if (samples_todo.size() != 0) begin
          in_flight = samples_todo.pop_front();
          sample_ch.valid <= 1'b1;
          sample_ch.pin_level <= in_flight.pin;
          sample_ch.now_time <= in_flight.stamp;
          sample_ch.collect <= in_flight.collect;
          send_gap <= ($urandom_range(0, 99) < idle_pct) ? gap_len() : 0;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      stall_left <= LONG_HOLD;
      result_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= gap_len() - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (reports_due.size() == 0) begin
        flag_mismatch($sformatf("report %0d arrived with nothing outstanding", report_idx));
      end else begin
        want = reports_due.pop_front();
        if (result_ch.pending_mask !== want.mask) begin
          flag_mismatch($sformatf("report %0d pending_mask got %b want %b",
                                  report_idx, result_ch.pending_mask, want.mask));
        end
        if (result_ch.is_pressed !== want.pressed) begin
          flag_mismatch($sformatf("report %0d is_pressed got %b want %b",
                                  report_idx, result_ch.is_pressed, want.pressed));
        end
      end
      report_idx++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("button_click_event_detector_core regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      CFG_ACTIVE_LEVEL:    det_cfg.press_level = val[0];
      CFG_DEBOUNCE_TIME:   det_cfg.debounce_time = val;
      CFG_LONG_PRESS_TIME: det_cfg.long_press_time = val;
      CFG_CLICK_GAP_TIME:  det_cfg.click_gap_time = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (samples_todo.size() != 0 || sample_ch.valid || reports_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_sample(input bit pin, input logic [NOW_WIDTH-1:0] stamp,
                              input bit collect);
    pin_sample_t s;
    s.pin = pin;
    s.stamp = stamp;
    s.collect = collect;
    samples_todo.push_back(s);
    queued++;
  endtask

  task automatic step_sample(input bit pin, input int unsigned dt);
    sim_ms = sim_ms + NOW_WIDTH'(dt);
    queue_sample(pin, sim_ms, $urandom_range(0, 2) == 0);
  endtask

  // land exactly on the span so the at-threshold compare gets hit
  task automatic hold_level(input bit lvl, input int unsigned span);
    int unsigned done_ms;
    int unsigned step;
    done_ms = 0;
    do begin
      step = $urandom_range(1, span / 3 + 1);
      if (step > span - done_ms) begin
        step = span - done_ms;
      end
      step_sample(lvl, step);
      done_ms += step;
    end while (done_ms < span);
  endtask

  task automatic press_sequence();
    bit on;
    bit off;
    int unsigned deb;
    int unsigned lp;
    int unsigned gap;
    int unsigned kind;
    on = det_cfg.press_level;
    off = !on;
    deb = det_cfg.debounce_time;
    lp = det_cfg.long_press_time;
    gap = det_cfg.click_gap_time;
    kind = $urandom_range(0, 11);
    case (kind)
      0, 1, 2: begin
        hold_level(on, deb + $urandom_range(0, 3));
        hold_level(off, deb + $urandom_range(0, 3));
        hold_level(off, gap + $urandom_range(0, 3));
      end
      3, 4: begin
        hold_level(on, deb + $urandom_range(0, 3));
        hold_level(off, deb + $urandom_range(0, 3));
        hold_level(on, deb + $urandom_range(0, 3));
        hold_level(off, deb + $urandom_range(0, 3));
        hold_level(off, gap + $urandom_range(0, 2));
      end
      5, 6: begin
        hold_level(on, deb + lp + $urandom_range(0, 3));
        hold_level(off, deb + $urandom_range(0, 3));
      end
      7: begin
        hold_level(on, deb + $urandom_range(0, 3));
        hold_level(off, deb + $urandom_range(0, 3));
        hold_level(on, deb + lp + $urandom_range(0, 3));
        hold_level(off, deb + $urandom_range(0, 3));
      end
      8: begin
        repeat ($urandom_range(2, 6)) step_sample($urandom_range(0, 1), $urandom_range(0, deb / 2));
      end
      9: begin
        repeat ($urandom_range(3, 10)) begin
          step_sample($urandom_range(0, 1), $urandom_range(0, (deb + gap) / 2 + 2));
        end
      end
      10: step_sample($urandom_range(0, 1), $urandom());
      default: hold_level(off, gap + $urandom_range(0, 3));
    endcase
  endtask

  task automatic run_phase(input logic [15:0] lvl_word, input logic [15:0] deb,
                           input logic [15:0] lp, input logic [15:0] gap,
                           input int unsigned pct, input bit squeeze);
    int unsigned target;
    drain();
    write_reg(CFG_ACTIVE_LEVEL, lvl_word);
    write_reg(CFG_DEBOUNCE_TIME, deb);
    write_reg(CFG_LONG_PRESS_TIME, lp);
    write_reg(CFG_CLICK_GAP_TIME, gap);
    idle_pct <= pct;
    if (squeeze) begin
      holds_asked <= holds_asked + 1;
    end
    target = queued + PHASE_ITEMS;
    while (queued < target) begin
      press_sequence();
    end
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.pin_level = 1'b0;
    sample_ch.now_time = '0;
    sample_ch.collect = 1'b0;
    result_ch.ready = 1'b0;
    cycles = 0;
    err_count = 0;
    report_idx = 0;
    queued = 0;
    idle_pct = 0;
    holds_asked = 0;
    holds_served = 0;
    det_cfg.press_level = 1'b0;
    det_cfg.debounce_time = DEBOUNCE_RESET;
    det_cfg.long_press_time = LONG_PRESS_RESET;
    det_cfg.click_gap_time = CLICK_GAP_RESET;
    det_state = ST_RELEASED;
    held = 1'b0;
    long_fired = 1'b0;
    click_armed = 1'b0;
    chg_stamp = '0;
    press_stamp = '0;
    rel_stamp = '0;
    ev_pending = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset register values, pin low counts as pressed
    idle_pct <= 25;
    queue_sample(1'b1, 32'hFFFF_FFF0, 1'b0);
    queue_sample(1'b0, 32'hFFFF_FFF8, 1'b0);
    queue_sample(1'b0, 32'h0000_000B, 1'b0);
    queue_sample(1'b0, 32'h0000_000C, 1'b0);
    queue_sample(1'b1, 32'h0000_000D, 1'b1);
    queue_sample(1'b1, 32'h0000_0021, 1'b0);
    queue_sample(1'b0, 32'h0000_0030, 1'b0);
    queue_sample(1'b0, 32'h0000_0044, 1'b1);
    queue_sample(1'b1, 32'h0000_0045, 1'b0);
    queue_sample(1'b1, 32'h0000_0059, 1'b0);
    queue_sample(1'b0, 32'h0000_0100, 1'b0);
    queue_sample(1'b0, 32'h0000_0114, 1'b0);
    queue_sample(1'b0, 32'h0000_04FB, 1'b0);
    queue_sample(1'b0, 32'h0000_04FC, 1'b0);
    queue_sample(1'b1, 32'h0000_0500, 1'b0);
    queue_sample(1'b0, 32'h0000_0501, 1'b0);
    queue_sample(1'b1, 32'h0000_0502, 1'b0);
    queue_sample(1'b1, 32'h0000_0516, 1'b1);
    queue_sample(1'b0, 32'h0000_0600, 1'b0);
    queue_sample(1'b1, 32'h0000_0601, 1'b0);
    queue_sample(1'b0, 32'h0000_0700, 1'b0);
    queue_sample(1'b0, 32'h0000_0714, 1'b0);
    queue_sample(1'b1, 32'h0000_0715, 1'b0);
    queue_sample(1'b1, 32'h0000_0729, 1'b0);
    queue_sample(1'b1, 32'h0000_0854, 1'b1);
    queue_sample(1'b1, 32'h0000_0855, 1'b1);
    sim_ms = 32'h0000_0855;

    run_phase(16'h0000, 16'd20, 16'd1000, 16'd300, 20, 1'b1);
    run_phase(16'h0001, 16'd0, 16'd0, 16'd0, 0, 1'b0);
    run_phase(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 40, 1'b0);
    run_phase(16'h8001, 16'd1, 16'hFFFF, 16'd0, 10, 1'b0);
    run_phase(16'h0000, 16'd0, 16'd3, 16'hFFFF, 30, 1'b1);
    repeat (3) begin
      run_phase(16'($urandom()), 16'($urandom_range(0, 40)), 16'($urandom_range(0, 200)),
                16'($urandom_range(0, 80)), $urandom_range(0, 50), 1'b0);
    end
    drain();

    if (reports_due.size() != 0) begin
      flag_mismatch($sformatf("%0d reports never arrived", reports_due.size()));
    end
    if (err_count == 0) begin
      $display("button_click_event_detector_core regression: pass");
    end else begin
      $display("button_click_event_detector_core regression: fail");
    end
    $finish;
  end

endmodule
